// ----- hdl/lar_pkg.sv -----
// ----------------------------------------------------------------------------
// lar_pkg: shared definitions for the antialiased line rasterizer
// Default widths, command and register codes, sequencer and line mode
// encodings, and the saturating colour adder.
// ----------------------------------------------------------------------------
package lar_pkg;

	// default geometry and precision
	localparam int COORD_BITS_DEF     = 13;
	localparam int ERROR_BITS_DEF     = 16;
	localparam int INTENSITY_BITS_DEF = 8;

	// fixed field widths
	localparam int COLOUR_BITS = 8;
	localparam int DIM_BITS    = 13;
	localparam int PADDR_BITS  = 3;
	localparam int PDATA_BITS  = 32;

	localparam logic [COLOUR_BITS-1:0] COLOUR_MAX = 8'd255;

	// request commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// register index (byte address bit 2)
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd1024;

	// request sequencer
	typedef enum logic [3:0] {
		SEQ_IDLE  = 4'b0001,
		SEQ_EMIT0 = 4'b0010,
		SEQ_EMIT1 = 4'b0100,
		SEQ_DIV   = 4'b1000
	} seq_state_t;

	// kind of line being walked
	typedef enum logic [6:0] {
		MODE_IDLE    = 7'b0000001,
		MODE_HORIZ   = 7'b0000010,
		MODE_VERT    = 7'b0000100,
		MODE_DIAG    = 7'b0001000,
		MODE_YWEIGHT = 7'b0010000,
		MODE_XWEIGHT = 7'b0100000,
		MODE_FINAL   = 7'b1000000
	} line_mode_t;

	// base + weight + offset, clamped to full white
	function automatic logic [COLOUR_BITS-1:0] sat_colour(
		input logic [COLOUR_BITS-1:0] base,
		input logic [COLOUR_BITS-1:0] weight,
		input logic [COLOUR_BITS-1:0] offset
	);
		logic [COLOUR_BITS+1:0] sum;
		sum = (COLOUR_BITS+2)'(base) + (COLOUR_BITS+2)'(weight) + (COLOUR_BITS+2)'(offset);
		return (sum > (COLOUR_BITS+2)'(COLOUR_MAX)) ? COLOUR_MAX : sum[COLOUR_BITS-1:0];
	endfunction

endpackage

// ----- hdl/lar_if.sv -----
// ----------------------------------------------------------------------------
// lar_if: request and pixel channels of the line rasterizer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// line request channel
interface lar_cmd_if #(
	parameter int COORD_BITS = lar_pkg::COORD_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic                               command;
	logic signed [COORD_BITS-1:0]       x_start;
	logic signed [COORD_BITS-1:0]       y_start;
	logic signed [COORD_BITS-1:0]       x_end;
	logic signed [COORD_BITS-1:0]       y_end;
	logic [lar_pkg::COLOUR_BITS-1:0]    base_colour;
	logic [lar_pkg::COLOUR_BITS-1:0]    colour_offset;

	modport source (
		output valid, command, x_start, y_start, x_end, y_end, base_colour, colour_offset,
		input  ready
	);
	modport sink (
		input  valid, command, x_start, y_start, x_end, y_end, base_colour, colour_offset,
		output ready
	);
endinterface

// pixel channel
interface lar_pix_if #(
	parameter int COORD_BITS = lar_pkg::COORD_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic signed [COORD_BITS-1:0]       pixel_x;
	logic signed [COORD_BITS-1:0]       pixel_y;
	logic [lar_pkg::COLOUR_BITS-1:0]    pixel_colour;
	logic                               in_image;
	logic                               last;

	modport source (
		output valid, pixel_x, pixel_y, pixel_colour, in_image, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_colour, in_image, last,
		output ready
	);
endinterface

// ----- hdl/lar_div.sv -----
// ----------------------------------------------------------------------------
// lar_div: restoring divider for the error step
// Computes (numer << QUO_BITS) / denom, one quotient bit per cycle, with
// one shared subtractor. Requires numer < denom.
// ----------------------------------------------------------------------------
module lar_div #(
	parameter int NUM_BITS = lar_pkg::COORD_BITS_DEF,
	parameter int QUO_BITS = lar_pkg::ERROR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] numer,
	input  logic [NUM_BITS-1:0] denom,
	output logic                busy,
	output logic [QUO_BITS-1:0] quotient
);
	localparam int CNT_W = $clog2(QUO_BITS + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] den_q;
	logic [QUO_BITS-1:0] quo_q;

	logic [NUM_BITS:0]   shifted;
	logic [NUM_BITS:0]   diff;
	logic                fits;

	// trial subtraction
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			den_q <= denom;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

// ----- hdl/antialiased_line_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core: Wu antialiased line walker
// A start request loads two endpoints and colours and yields the first
// pixel; each step request yields the next pixel or weighted pixel pair.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : request channel. command = start loads a line (endpoints are
//            ordered top to bottom), command = step advances it by one.
//   pixel  : one pixel per transfer, with in_image and last flags.
//   APB    : image_width at 0x0, image_height at 0x4; write only when idle.
// Timing:
//   cmd.ready is high only while the sequencer is idle. A request is
//   turned into at most two staged pixels, moved one per cycle into the
//   output register unless the receiver stalls; the first pixel passes
//   through the staging register and then the output register. A start of
//   a line that is neither straight nor diagonal also waits for the
//   one-bit-per-cycle restoring divider that forms the error step.
//   A step request with no line in progress yields nothing.
// Reset clears all line state and sets both image sizes to 1024. When the
// receiver stalls, the output register holds its pixel and the sequencer
// waits, so cmd.ready stays low until the pending pixels have moved on.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_core #(
	parameter int COORD_BITS     = lar_pkg::COORD_BITS_DEF,
	parameter int ERROR_BITS     = lar_pkg::ERROR_BITS_DEF,
	parameter int INTENSITY_BITS = lar_pkg::INTENSITY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lar_cmd_if.sink                        cmd,
	lar_pix_if.source                      pixel,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lar_pkg::PADDR_BITS-1:0] paddr,
	input  logic [lar_pkg::PDATA_BITS-1:0] pwdata,
	output logic [lar_pkg::PDATA_BITS-1:0] prdata,
	output logic                           pready
);
	import lar_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int CW    = COORD_BITS + 1;
	localparam int CMP_W = (CB > DIM_BITS) ? CB : DIM_BITS;

	// configuration registers
	logic [DIM_BITS-1:0] width_q, height_q;
	logic                cfg_wr;

	// line state
	seq_state_t              seq_q, seq_d;
	line_mode_t              mode_q, mode_d;
	logic signed [CB-1:0]    cur_col_q, cur_col_d, cur_row_q, cur_row_d;
	logic signed [CB-1:0]    end_col_q, end_col_d, end_row_q, end_row_d;
	logic                    col_dir_q, col_dir_d;
	logic [CB-1:0]           steps_q, steps_d;
	logic [ERROR_BITS-1:0]   acc_q, acc_d, estep_q, estep_d;
	logic [COLOUR_BITS-1:0]  colour_q, colour_d, offset_q, offset_d;

	// staged pixels
	logic signed [CW-1:0]    p0_x_q, p0_x_d, p0_y_q, p0_y_d;
	logic signed [CW-1:0]    p1_x_q, p1_x_d, p1_y_q, p1_y_d;
	logic [COLOUR_BITS-1:0]  p0_c_q, p0_c_d, p1_c_q, p1_c_d;
	logic                    p0_last_q, p0_last_d;
	logic                    p1_pend_q, p1_pend_d, div_pend_q, div_pend_d;

	// output register
	logic                    out_valid_q;
	logic signed [CB-1:0]    out_x_q, out_y_q;
	logic [COLOUR_BITS-1:0]  out_c_q;
	logic                    out_in_q, out_last_q;
	logic                    out_load;
	logic signed [CW-1:0]    sel_x, sel_y;
	logic [COLOUR_BITS-1:0]  sel_c;
	logic                    sel_last;

	// divider hookup
	logic                    div_start, div_busy;
	logic [CB-1:0]           div_numer, div_denom;
	logic [ERROR_BITS-1:0]   div_quo;

	logic                    accept;

	// start decode
	logic signed [CB-1:0]    sx0, sy0, sx1, sy1;
	logic signed [CW-1:0]    s_dx, s_dy, s_ndx;
	logic                    s_dir;
	logic [CB-1:0]           s_adx, s_ady;

	// step arithmetic
	logic signed [CB-1:0]    dir_v, col_inc, row_inc, w_col, w_row;
	logic [CB-1:0]           steps_dec;
	logic [ERROR_BITS-1:0]   acc_sum;
	logic                    turn;
	logic [INTENSITY_BITS-1:0] wt, wt_c;

	function automatic logic in_img(
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y,
		input logic [DIM_BITS-1:0]  w,
		input logic [DIM_BITS-1:0]  h
	);
		logic [CMP_W-1:0] xe, ye, we, he;
		xe = CMP_W'(x[CB-1:0]);
		ye = CMP_W'(y[CB-1:0]);
		we = CMP_W'(w);
		he = CMP_W'(h);
		return !x[CB] && !y[CB] && (xe < we) && (ye < he);
	endfunction

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = PDATA_BITS'(width_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_BITS'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign cmd.ready = (seq_q == SEQ_IDLE);
	assign accept    = cmd.valid & cmd.ready;

	// endpoint ordering and deltas for a start request
	always_comb begin
		if (cmd.y_start > cmd.y_end) begin
			sx0 = cmd.x_end;
			sy0 = cmd.y_end;
			sx1 = cmd.x_start;
			sy1 = cmd.y_start;
		end else begin
			sx0 = cmd.x_start;
			sy0 = cmd.y_start;
			sx1 = cmd.x_end;
			sy1 = cmd.y_end;
		end
	end

	assign s_dx  = CW'(sx1) - CW'(sx0);
	assign s_dy  = CW'(sy1) - CW'(sy0);
	assign s_ndx = -s_dx;
	assign s_dir = s_dx[CB];
	assign s_adx = s_dir ? s_ndx[CB-1:0] : s_dx[CB-1:0];
	assign s_ady = s_dy[CB-1:0];

	// one step along the current line
	assign dir_v     = col_dir_q ? {CB{1'b1}} : CB'(1);
	assign col_inc   = cur_col_q + dir_v;
	assign row_inc   = cur_row_q + CB'(1);
	assign steps_dec = steps_q - CB'(1);
	assign acc_sum   = acc_q + estep_q;
	assign turn      = acc_sum <= acc_q;
	assign wt        = acc_sum[ERROR_BITS-1 -: INTENSITY_BITS];
	assign wt_c      = ~wt;
	assign w_col     = (mode_q == MODE_YWEIGHT) ? (turn ? col_inc : cur_col_q) : col_inc;
	assign w_row     = (mode_q == MODE_YWEIGHT) ? row_inc : (turn ? row_inc : cur_row_q);

	// sequencer and line state update
	always_comb begin
		seq_d      = seq_q;
		mode_d     = mode_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		end_col_d  = end_col_q;
		end_row_d  = end_row_q;
		col_dir_d  = col_dir_q;
		steps_d    = steps_q;
		acc_d      = acc_q;
		estep_d    = estep_q;
		colour_d   = colour_q;
		offset_d   = offset_q;
		p0_x_d     = p0_x_q;
		p0_y_d     = p0_y_q;
		p0_c_d     = p0_c_q;
		p0_last_d  = p0_last_q;
		p1_x_d     = p1_x_q;
		p1_y_d     = p1_y_q;
		p1_c_d     = p1_c_q;
		p1_pend_d  = p1_pend_q;
		div_pend_d = div_pend_q;
		div_start  = 1'b0;
		div_numer  = s_adx;
		div_denom  = s_ady;

		case (seq_q)
			SEQ_IDLE: begin
				if (accept && cmd.command == CMD_START) begin
					colour_d   = cmd.base_colour;
					offset_d   = cmd.colour_offset;
					cur_col_d  = sx0;
					cur_row_d  = sy0;
					end_col_d  = sx1;
					end_row_d  = sy1;
					acc_d      = '0;
					estep_d    = '0;
					col_dir_d  = s_dir;
					p0_x_d     = CW'(sx0);
					p0_y_d     = CW'(sy0);
					p0_c_d     = sat_colour(cmd.base_colour, '0, cmd.colour_offset);
					p0_last_d  = (s_adx == '0) && (s_ady == '0);
					p1_pend_d  = 1'b0;
					div_pend_d = 1'b0;
					seq_d      = SEQ_EMIT0;
					if (s_ady == '0) begin
						mode_d  = (s_adx != '0) ? MODE_HORIZ : MODE_IDLE;
						steps_d = s_adx;
					end else if (s_adx == '0) begin
						mode_d  = MODE_VERT;
						steps_d = s_ady;
					end else if (s_adx == s_ady) begin
						mode_d  = MODE_DIAG;
						steps_d = s_ady;
					end else if (s_ady > s_adx) begin
						mode_d     = MODE_YWEIGHT;
						steps_d    = s_ady - CB'(1);
						div_start  = 1'b1;
						div_pend_d = 1'b1;
					end else begin
						mode_d     = MODE_XWEIGHT;
						steps_d    = s_adx - CB'(1);
						div_start  = 1'b1;
						div_pend_d = 1'b1;
						div_numer  = s_ady;
						div_denom  = s_adx;
					end
				end else if (accept) begin
					p1_pend_d  = 1'b0;
					div_pend_d = 1'b0;
					case (mode_q)
						MODE_HORIZ, MODE_VERT, MODE_DIAG: begin
							if (mode_q != MODE_VERT) begin
								cur_col_d = col_inc;
							end
							if (mode_q != MODE_HORIZ) begin
								cur_row_d = row_inc;
							end
							steps_d   = steps_dec;
							p0_x_d    = CW'((mode_q != MODE_VERT) ? col_inc : cur_col_q);
							p0_y_d    = CW'((mode_q != MODE_HORIZ) ? row_inc : cur_row_q);
							p0_c_d    = sat_colour(colour_q, '0, offset_q);
							p0_last_d = (steps_dec == '0);
							if (steps_dec == '0) begin
								mode_d = MODE_IDLE;
							end
							seq_d = SEQ_EMIT0;
						end
						MODE_YWEIGHT, MODE_XWEIGHT: begin
							acc_d     = acc_sum;
							cur_col_d = w_col;
							cur_row_d = w_row;
							steps_d   = steps_dec;
							p0_x_d    = CW'(w_col);
							p0_y_d    = CW'(w_row);
							p0_c_d    = sat_colour(colour_q, COLOUR_BITS'(wt), offset_q);
							p0_last_d = 1'b0;
							if (mode_q == MODE_YWEIGHT) begin
								p1_x_d = CW'(w_col) + CW'(dir_v);
								p1_y_d = CW'(w_row);
							end else begin
								p1_x_d = CW'(w_col);
								p1_y_d = CW'(w_row) + CW'(1);
							end
							p1_c_d    = sat_colour(colour_q, COLOUR_BITS'(wt_c), offset_q);
							p1_pend_d = 1'b1;
							if (steps_dec == '0) begin
								mode_d = MODE_FINAL;
							end
							seq_d = SEQ_EMIT0;
						end
						MODE_FINAL: begin
							cur_col_d = end_col_q;
							cur_row_d = end_row_q;
							p0_x_d    = CW'(end_col_q);
							p0_y_d    = CW'(end_row_q);
							p0_c_d    = sat_colour(colour_q, '0, offset_q);
							p0_last_d = 1'b1;
							mode_d    = MODE_IDLE;
							seq_d     = SEQ_EMIT0;
						end
						default: begin
							mode_d = MODE_IDLE;
						end
					endcase
				end
			end
			SEQ_EMIT0: begin
				if (out_load) begin
					if (p1_pend_q) begin
						seq_d = SEQ_EMIT1;
					end else if (div_pend_q) begin
						seq_d = SEQ_DIV;
					end else begin
						seq_d = SEQ_IDLE;
					end
				end
			end
			SEQ_EMIT1: begin
				if (out_load) begin
					seq_d = SEQ_IDLE;
				end
			end
			SEQ_DIV: begin
				// error step ready once the divider has run out
				if (!div_busy) begin
					estep_d = div_quo;
					seq_d   = SEQ_IDLE;
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= SEQ_IDLE;
			mode_q     <= MODE_IDLE;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			end_col_q  <= '0;
			end_row_q  <= '0;
			col_dir_q  <= 1'b0;
			steps_q    <= '0;
			acc_q      <= '0;
			estep_q    <= '0;
			colour_q   <= '0;
			offset_q   <= '0;
			p1_pend_q  <= 1'b0;
			div_pend_q <= 1'b0;
		end else begin
			seq_q      <= seq_d;
			mode_q     <= mode_d;
			cur_col_q  <= cur_col_d;
			cur_row_q  <= cur_row_d;
			end_col_q  <= end_col_d;
			end_row_q  <= end_row_d;
			col_dir_q  <= col_dir_d;
			steps_q    <= steps_d;
			acc_q      <= acc_d;
			estep_q    <= estep_d;
			colour_q   <= colour_d;
			offset_q   <= offset_d;
			p1_pend_q  <= p1_pend_d;
			div_pend_q <= div_pend_d;
		end
	end

	// staged pixel payload
	always_ff @(posedge clk) begin
		p0_x_q    <= p0_x_d;
		p0_y_q    <= p0_y_d;
		p0_c_q    <= p0_c_d;
		p0_last_q <= p0_last_d;
		p1_x_q    <= p1_x_d;
		p1_y_q    <= p1_y_d;
		p1_c_q    <= p1_c_d;
	end

	// error step divider
	lar_div #(
		.NUM_BITS (CB),
		.QUO_BITS (ERROR_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.denom    (div_denom),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// output register
	assign out_load = ((seq_q == SEQ_EMIT0) || (seq_q == SEQ_EMIT1)) &&
	                  (!out_valid_q || pixel.ready);
	assign sel_x    = (seq_q == SEQ_EMIT1) ? p1_x_q : p0_x_q;
	assign sel_y    = (seq_q == SEQ_EMIT1) ? p1_y_q : p0_y_q;
	assign sel_c    = (seq_q == SEQ_EMIT1) ? p1_c_q : p0_c_q;
	assign sel_last = (seq_q == SEQ_EMIT1) ? 1'b0 : p0_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= sel_x[CB-1:0];
			out_y_q    <= sel_y[CB-1:0];
			out_c_q    <= sel_c;
			out_in_q   <= in_img(sel_x, sel_y, width_q, height_q);
			out_last_q <= sel_last;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_x      = out_x_q;
	assign pixel.pixel_y      = out_y_q;
	assign pixel.pixel_colour = out_c_q;
	assign pixel.in_image     = out_in_q;
	assign pixel.last         = out_last_q;

endmodule
